FILE: hdl/bitmap_page_allocator_assert.svh
// Assertion macros shared by the page allocator modules.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("page allocator assertion failed");
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("page allocator assertion failed");
`else
`define BPA_ASSERT_NOW(lbl, ante, cons)
`define BPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/bpa_pkg.sv
// Types, codes and helper functions of the bitmap page allocator.
package bpa_pkg;

   localparam int BASE_W   = 52;
   localparam int ADDR_W   = 64;
   localparam int WORD_W   = 64;
   localparam int BIT_W    = 6;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_OUT_OF_PAGES  = 3'd1,
      ST_MISALIGNED    = 3'd2,
      ST_BELOW_BASE    = 3'd3,
      ST_BEYOND_POOL   = 3'd4,
      ST_NOT_ALLOCATED = 3'd5
   } status_type;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] page_address;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_ALLOC_ADDR,
      S_FREE_SUB,
      S_FREE_RANGE,
      S_FREE_BIT,
      S_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
   } alu_in_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result;
      logic              carry;
   } alu_out_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } zero_hit_type;

   // Lowest clear bit of a bitmap word.
   function automatic zero_hit_type find_first_zero(input logic [WORD_W-1:0] word);
      zero_hit_type hit;
      hit.found = 1'b0;
      hit.idx   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            hit.found = 1'b1;
            hit.idx   = BIT_W'(i);
         end
      end
      return hit;
   endfunction

endpackage

FILE: hdl/bpa_alu.sv
// Shared 64-bit add/subtract unit used for address and range arithmetic.
module bpa_alu
   import bpa_pkg::*;
(
   input  alu_in_type  alu_in,
   output alu_out_type alu_out
);

   logic [ADDR_W:0] sum;

   always_comb begin
      if (alu_in.op == ALU_SUB) begin
         sum = {1'b0, alu_in.a} - {1'b0, alu_in.b};
      end else begin
         sum = {1'b0, alu_in.a} + {1'b0, alu_in.b};
      end
      alu_out.result = sum[ADDR_W-1:0];
      // On a subtract this bit is the borrow.
      alu_out.carry  = sum[ADDR_W];
   end

endmodule

FILE: hdl/bpa_bitmap_mem.sv
// Used-page bitmap memory with one write port and one registered read port.
module bpa_bitmap_mem
   import bpa_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bpa_ctrl.sv
// Sequencer of the page allocator: clear pass, word-serial scan and free checks.
`include "bitmap_page_allocator_assert.svh"
module bpa_ctrl
   import bpa_pkg::*;
#(
   parameter int NUM_PAGES  = 8192,
   parameter int PAGE_SHIFT = 12,
   parameter int WORDS      = 128,
   parameter int WIDX_W     = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   input  logic [BASE_W-1:0] base_page,
   input  logic              out_free,
   output logic              res_load,
   output rsp_type           res_data,
   output logic              wr_en,
   output logic [WIDX_W-1:0] wr_addr,
   output logic [WORD_W-1:0] wr_data,
   output logic [WIDX_W-1:0] rd_addr,
   input  logic [WORD_W-1:0] rd_data,
   output alu_in_type        alu_in,
   input  alu_out_type       alu_out
);

   localparam int PIDX_W = WIDX_W + BIT_W;
   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS - 1);
   localparam int VALID_LAST = NUM_PAGES - (WORDS - 1) * WORD_W;
   // Bits of the last word beyond the pool read as used so the scan skips them.
   localparam logic [WORD_W-1:0] SLACK_MASK =
      (VALID_LAST == WORD_W) ? '0 : ~((64'd1 << VALID_LAST) - 64'd1);

   state_type          state_ff, state_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;
   logic [PIDX_W-1:0]  pidx_ff, pidx_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  diff_ff, diff_in;
   logic               borrow_ff, borrow_in;
   rsp_type            res_ff, res_in;
   logic [WORD_W-1:0]  scan_word;
   zero_hit_type       hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff   <= pidx_in;
      addr_ff   <= addr_in;
      diff_ff   <= diff_in;
      borrow_ff <= borrow_in;
      res_ff    <= res_in;
   end

   always_comb begin
      scan_word = rd_data | ((widx_ff == LAST_WORD) ? SLACK_MASK : '0);
      hit       = find_first_zero(scan_word);
   end

   always_comb begin
      state_in  = state_ff;
      widx_in   = widx_ff;
      pidx_in   = pidx_ff;
      addr_in   = addr_ff;
      diff_in   = diff_ff;
      borrow_in = borrow_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      res_load  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = widx_ff;
      wr_data   = '0;
      rd_addr   = widx_ff;
      alu_in.op = ALU_ADD;
      alu_in.a  = '0;
      alu_in.b  = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (widx_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               widx_in = widx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = '0;
            if (req_valid) begin
               widx_in = '0;
               addr_in = req_data.free_address;
               if (req_data.op == OP_FREE) begin
                  state_in = S_FREE_SUB;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // rd_data holds word widx_ff; the next word is fetched meanwhile.
            if (hit.found) begin
               wr_en    = 1'b1;
               wr_data  = rd_data | (64'd1 << hit.idx);
               pidx_in  = {widx_ff, hit.idx};
               state_in = S_ALLOC_ADDR;
            end else if (widx_ff == LAST_WORD) begin
               res_in.status       = ST_OUT_OF_PAGES;
               res_in.page_address = '0;
               state_in            = S_DONE;
            end else begin
               widx_in = widx_ff + 1'b1;
               rd_addr = widx_ff + 1'b1;
            end
         end
         S_ALLOC_ADDR: begin
            alu_in.op           = ALU_ADD;
            alu_in.a            = ADDR_W'(base_page);
            alu_in.b            = ADDR_W'(pidx_ff);
            res_in.status       = ST_OK;
            res_in.page_address = alu_out.result << PAGE_SHIFT;
            state_in            = S_DONE;
         end
         S_FREE_SUB: begin
            alu_in.op = ALU_SUB;
            alu_in.a  = addr_ff >> PAGE_SHIFT;
            alu_in.b  = ADDR_W'(base_page);
            diff_in   = alu_out.result;
            borrow_in = alu_out.carry;
            res_in.page_address = '0;
            if (addr_ff[PAGE_SHIFT-1:0] != '0) begin
               res_in.status = ST_MISALIGNED;
               state_in      = S_DONE;
            end else begin
               state_in = S_FREE_RANGE;
            end
         end
         S_FREE_RANGE: begin
            pidx_in = diff_ff[PIDX_W-1:0];
            rd_addr = diff_ff[PIDX_W-1:BIT_W];
            if (borrow_ff) begin
               res_in.status = ST_BELOW_BASE;
               state_in      = S_DONE;
            end else if (diff_ff >= ADDR_W'(NUM_PAGES)) begin
               res_in.status = ST_BEYOND_POOL;
               state_in      = S_DONE;
            end else begin
               state_in = S_FREE_BIT;
            end
         end
         S_FREE_BIT: begin
            wr_addr  = pidx_ff[PIDX_W-1:BIT_W];
            wr_data  = rd_data & ~(64'd1 << pidx_ff[BIT_W-1:0]);
            state_in = S_DONE;
            if (rd_data[pidx_ff[BIT_W-1:0]]) begin
               wr_en         = 1'b1;
               res_in.status = ST_OK;
            end else begin
               res_in.status = ST_NOT_ALLOCATED;
            end
         end
         S_DONE: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

   `BPA_ASSERT_NOW(a_fail_addr_zero, res_load && res_ff.status != ST_OK, res_ff.page_address == '0)
   `BPA_ASSERT_NOW(a_scan_step, state_ff == S_SCAN && $past(state_ff) == S_SCAN, widx_ff == WIDX_W'($past(widx_ff) + 1'b1))
   `BPA_ASSERT_NEXT(a_clear_done, state_ff == S_CLEAR && widx_ff == LAST_WORD, state_ff == S_IDLE)

endmodule

FILE: hdl/bitmap_page_allocator.sv
// Bitmap page allocator: a request channel for allocate and free, one response per request,
// and a write port for the base page number.
//
// Requests enter on req_valid/req_ready with op and free_address; responses leave on
// rsp_valid/rsp_ready with status and page_address. The base page register is written
// through csr_valid/csr_data; csr_ready is always high, and writes belong in idle periods.
// One request is worked on at a time and req_ready is low while it is in progress.
// An allocate scans the bitmap one 64-bit word per cycle from the lowest page. When a free
// page turns up, S_SCAN sets its bit and S_ALLOC_ADDR adds the page index to the base page
// to form page_address; when the pool is full the status is ST_OUT_OF_PAGES. A free checks
// alignment and subtracts the base page in S_FREE_SUB, checks below base and beyond the
// pool in S_FREE_RANGE, and clears the page's bit or reports it not allocated in S_FREE_BIT.
// req_ready returns the cycle after the response is loaded into the output register.
// After reset the bitmap memory is cleared one word per cycle, which holds req_ready
// low until the last word has been cleared; the base page resets to 0.
// The response sits in an output register; while the receiver stalls, the next request
// may still be accepted and worked on, and its response waits until the register frees.
`include "bitmap_page_allocator_assert.svh"
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int NUM_PAGES  = 8192,
   parameter int PAGE_SHIFT = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BASE_W-1:0] csr_data
);

   localparam int WORDS  = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [BASE_W-1:0] base_page_ff, base_page_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              out_free;
   logic              res_load;
   rsp_type           res_data;
   logic              wr_en;
   logic [WIDX_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WIDX_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   alu_in_type        alu_in;
   alu_out_type       alu_out;

   bpa_ctrl #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .WORDS      (WORDS),
      .WIDX_W     (WIDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .base_page (base_page_ff),
      .out_free  (out_free),
      .res_load  (res_load),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .alu_in    (alu_in),
      .alu_out   (alu_out)
   );

   bpa_bitmap_mem #(
      .DEPTH (WORDS),
      .AW    (WIDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bpa_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      base_page_in = csr_valid ? csr_data : base_page_ff;
      rsp_data_in  = res_load ? res_data : rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_page_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_page_ff <= base_page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BPA_ASSERT_NOW(a_load_when_free, res_load, !rsp_valid_ff || rsp_ready)
   `BPA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   `BPA_ASSERT_NOW(a_rsp_from_load, $rose(rsp_valid_ff), $past(res_load))

endmodule
